### rtl/cpf_pkg.sv
package cpf_pkg;

  typedef enum logic [3:0] {
    PRED_EQ     = 4'd0,
    PRED_NE     = 4'd1,
    PRED_LT     = 4'd2,
    PRED_GT     = 4'd3,
    PRED_LE     = 4'd4,
    PRED_GE     = 4'd5,
    PRED_IN     = 4'd6,
    PRED_NIN    = 4'd7,
    PRED_EXISTS = 4'd8,
    PRED_PASS   = 4'd9
  } pred_t;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PREDICATE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FIELD_PRESENT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIST_COUNT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIST_A        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LIST_B        = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LIST_C        = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LIST_D        = 3'd7;

  typedef struct packed {
    logic [63:0] row_value;
    logic        is_null;
    logic        alive_in;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic        keep;
    logic [9:0]  slot;
    logic [10:0] kept_total;
    logic        last_out;
  } out_item_t;

  // IEEE compare flags of a against b
  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_t;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic cmp_t fcmp(input logic [63:0] a, input logic [63:0] b);
    cmp_t r;
    logic both_zero;
    logic mag_lt;
    logic mag_gt;
    r = '0;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    mag_lt = a[62:0] < b[62:0];
    mag_gt = a[62:0] > b[62:0];
    if (!is_nan(a) && !is_nan(b)) begin
      if (both_zero || a == b) begin
        r.eq = 1'b1;
      end else if (a[63] != b[63]) begin
        r.lt = a[63];
        r.gt = b[63];
      end else if (a[63]) begin
        r.lt = mag_gt;
        r.gt = mag_lt;
      end else begin
        r.lt = mag_lt;
        r.gt = mag_gt;
      end
    end
    return r;
  endfunction

endpackage

### rtl/cpf_in_if.sv
interface cpf_in_if;
  logic                valid;
  logic                ready;
  cpf_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/cpf_out_if.sv
interface cpf_out_if;
  logic                valid;
  logic                ready;
  cpf_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/column_predicate_filter.sv
// Path: a row passes the input register, then the result register (input reg, result reg);
// its result transfers while it sits in the result register and out_ch.ready is high.
// Throughput: one row per cycle; the input stage refills while the result
// register drains, so a stalled output only stalls once both regs are full.
// Reset (rst_n low, synchronous): both stages empty, kept count 0,
// predicate pass, field present, threshold/list values 0, list count 0.
module column_predicate_filter #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned LIST_SIZE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cpf_in_if.sink      in_ch,
  cpf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [3:0]  predicate_r;
  logic        field_present_r;
  logic [63:0] threshold_r;
  logic [2:0]  list_count_r;
  logic [63:0] list_vals_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      predicate_r     <= cpf_pkg::PRED_PASS;
      field_present_r <= 1'b1;
      threshold_r     <= '0;
      list_count_r    <= '0;
      for (int i = 0; i < 4; i++) list_vals_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpf_pkg::REG_PREDICATE:     predicate_r     <= cfg_data[3:0];
        cpf_pkg::REG_FIELD_PRESENT: field_present_r <= cfg_data[0];
        cpf_pkg::REG_THRESHOLD:     threshold_r     <= cfg_data;
        cpf_pkg::REG_LIST_COUNT:    list_count_r    <= cfg_data[2:0];
        cpf_pkg::REG_LIST_A:        list_vals_r[0]  <= cfg_data;
        cpf_pkg::REG_LIST_B:        list_vals_r[1]  <= cfg_data;
        cpf_pkg::REG_LIST_C:        list_vals_r[2]  <= cfg_data;
        cpf_pkg::REG_LIST_D:        list_vals_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: input register
  logic              s1_valid_r;
  cpf_pkg::in_item_t s1_r;
  // stage 2: result register
  logic               out_valid_r;
  cpf_pkg::out_item_t out_r;
  logic [CntW-1:0]    kept_count_r;

  logic s2_load;
  logic s1_load;
  assign s2_load = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign s1_load = in_ch.valid && in_ch.ready;

  logic keep;
  cpf_eval #(.LIST_SIZE(LIST_SIZE)) u_eval (
    .row_value    (s1_r.row_value),
    .is_null      (s1_r.is_null),
    .alive_in     (s1_r.alive_in),
    .predicate    (predicate_r),
    .field_present(field_present_r),
    .threshold    (threshold_r),
    .list_count   (list_count_r),
    .list_vals    (list_vals_r),
    .keep         (keep)
  );

  // slot assignment; count saturates at MAX_ROWS
  logic            at_max;
  logic [CntW-1:0] slot_full;
  logic [CntW-1:0] cnt_after;
  logic [CntW-1:0] kept_count_nxt;
  cpf_pkg::out_item_t out_nxt;
  always_comb begin
    at_max    = kept_count_r == CntW'(MAX_ROWS);
    slot_full = at_max ? CntW'(MAX_ROWS - 1) : kept_count_r;
    cnt_after = (keep && !at_max) ? kept_count_r + CntW'(1) : kept_count_r;
    out_nxt.keep       = keep;
    out_nxt.slot       = keep ? 10'(slot_full) : 10'd0;
    out_nxt.kept_total = 11'(cnt_after);
    out_nxt.last_out   = s1_r.last_row;
    kept_count_nxt     = s1_r.last_row ? '0 : cnt_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      kept_count_r <= '0;
    end else begin
      if (s1_load) s1_valid_r <= 1'b1;
      else if (s2_load) s1_valid_r <= 1'b0;
      if (s2_load) begin
        out_valid_r  <= 1'b1;
        kept_count_r <= kept_count_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) s1_r <= in_ch.data;
    if (s2_load) out_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // count never exceeds the cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kept_count_r <= CntW'(MAX_ROWS)) else $error("kept count over cap");
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("result changed under stall");
  // a dropped row gets slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.keep |-> out_r.slot == 10'd0)
    else $error("slot on dropped row");
  // count clears after batch end
  a_batch_clr: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && s1_r.last_row |=> kept_count_r == '0)
    else $error("count not cleared");
endmodule

### rtl/cpf_eval.sv
// Predicate decision for one row (combinational).
module cpf_eval #(
  parameter int unsigned LIST_SIZE = 4
) (
  input  logic [63:0] row_value,
  input  logic        is_null,
  input  logic        alive_in,
  input  logic [3:0]  predicate,
  input  logic        field_present,
  input  logic [63:0] threshold,
  input  logic [2:0]  list_count,
  input  logic [63:0] list_vals [4],
  output logic        keep
);
  cpf_pkg::cmp_t c;
  cpf_pkg::cmp_t lc;
  logic          live;
  logic          match;

  always_comb begin
    c     = cpf_pkg::fcmp(row_value, threshold);
    live  = alive_in && !is_null;
    match = 1'b0;
    lc    = '0;
    for (int j = 0; j < LIST_SIZE; j++) begin
      lc = cpf_pkg::fcmp(row_value, list_vals[j]);
      if (3'(j) < list_count && lc.eq) begin
        match = 1'b1;
      end
    end
    case (predicate)
      cpf_pkg::PRED_EQ:     keep = live && c.eq;
      cpf_pkg::PRED_NE:     keep = live && !c.eq;
      cpf_pkg::PRED_LT:     keep = live && c.lt;
      cpf_pkg::PRED_GT:     keep = live && c.gt;
      cpf_pkg::PRED_LE:     keep = live && (c.lt || c.eq);
      cpf_pkg::PRED_GE:     keep = live && (c.gt || c.eq);
      cpf_pkg::PRED_IN:     keep = live && match;
      cpf_pkg::PRED_NIN:    keep = live && !match;
      cpf_pkg::PRED_EXISTS: keep = live;
      default:              keep = alive_in;
    endcase
    if (!field_present) keep = 1'b0;
  end
endmodule
